/* rtl/ikt_pkg.sv */
// Shared types and constants for the id interning table.
// Used by ikt_key_mem, ikt_ctrl, ikt_out_stage and id_interning_table.
`timescale 1ns / 1ps

package ikt_pkg;

    // Default table size and stored key width
    localparam int CAPACITY_DEF  = 255;
    localparam int KEY_WIDTH_DEF = 64;

    // Fixed port field widths
    localparam int KEY_PORT_W  = 64;
    localparam int NUM_PORT_W  = 8;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 72;  // key, local_number
    localparam int OUT_TDATA_W = 72;  // result_number, result_key

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_FIND_KEY = 2'd1,
        OP_FIND_NUM = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_NEW     = 2'd0,
        STAT_FOUND   = 2'd1,
        STAT_MISSING = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    // Key memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // One finished result word
    typedef struct packed {
        status_t               status;
        logic [NUM_PORT_W-1:0] number;
        logic [KEY_PORT_W-1:0] key;
    } res_t;

endpackage

/* rtl/id_interning_table.sv */
// Top level of the id interning table: key memory, sequencer and output register.
// Depends on ikt_pkg, ikt_key_mem, ikt_ctrl and ikt_out_stage.
//
// Usage:
//   The slave channel takes one request word: tuser carries the opcode
//   (insert, number by key, key by number), tdata the key and local number.
//   The master channel returns one word per request: tuser carries the
//   status, tdata the result number and result key.
//   Numbers are handed out from 1; 0 means invalid. At most CAPACITY keys.
// Timing:
//   One request is worked at a time. Insert and lookup by key scan the
//   stored keys through the single memory read port, one entry a cycle.
//   Lookup by number takes one memory read.
//   s_axis_tready is high whenever no request is in progress; a result
//   waiting in the output register does not block the next request.
// Reset:
//   aresetn (synchronous, active low) empties the table at once; the key
//   memory holds no reset state and needs no clearing pass.
// Stall:
//   When the receiver holds m_axis_tready low, one result waits in the
//   output register and the next one waits in the sequencer.
`timescale 1ns / 1ps

module id_interning_table #(
    parameter int CAPACITY  = ikt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ikt_pkg::KEY_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request words
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ikt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // key[63:0], local_number[71:64]
    input  logic [ikt_pkg::OP_W-1:0]         s_axis_tuser,  // opcode[1:0]
    // Result words
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ikt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // result_number[7:0], result_key[71:8]
    output logic [ikt_pkg::STAT_W-1:0]       m_axis_tuser   // status[1:0]
);

    localparam int NUM_W  = $clog2(CAPACITY + 2);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KP     = ikt_pkg::KEY_PORT_W;

    ikt_pkg::mem_ctl_t    mem_ctl;
    logic [ADDR_W-1:0]    mem_wr_addr;
    logic [ADDR_W-1:0]    mem_rd_addr;
    logic [KEY_WIDTH-1:0] mem_wr_data;
    logic [KEY_WIDTH-1:0] mem_rd_data;
    logic                 res_valid;
    logic                 res_ready;
    ikt_pkg::res_t        res;

    ikt_key_mem #(
        .DEPTH  (CAPACITY),
        .WIDTH  (KEY_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ikt_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .NUM_W     (NUM_W),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_key      (s_axis_tdata[KEY_WIDTH-1:0]),
        .in_num      (s_axis_tdata[KP +: ikt_pkg::NUM_PORT_W]),
        .mem_ctl     (mem_ctl),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    ikt_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* rtl/ikt_key_mem.sv */
// Key store: synchronous memory, one write port, one read port, registered read data.
// Depends on ikt_pkg for the port strobe struct.
`timescale 1ns / 1ps

module ikt_key_mem #(
    parameter int DEPTH  = ikt_pkg::CAPACITY_DEF,
    parameter int WIDTH  = ikt_pkg::KEY_WIDTH_DEF,
    parameter int ADDR_W = 8
) (
    input  logic                aclk,
    input  ikt_pkg::mem_ctl_t   ctl,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [WIDTH-1:0]    wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [WIDTH-1:0]    rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ikt_ctrl.sv */
// Sequencer for the interning table: key scan, reverse read and insert write-back.
// Depends on ikt_pkg; drives ikt_key_mem and hands results to ikt_out_stage.
`timescale 1ns / 1ps

module ikt_ctrl #(
    parameter int CAPACITY  = ikt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = ikt_pkg::KEY_WIDTH_DEF,
    parameter int NUM_W     = 9,
    parameter int ADDR_W    = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input word
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ikt_pkg::OP_W-1:0]          in_op,
    input  logic [KEY_WIDTH-1:0]              in_key,
    input  logic [ikt_pkg::NUM_PORT_W-1:0]    in_num,
    // Key memory
    output ikt_pkg::mem_ctl_t                 mem_ctl,
    output logic [ADDR_W-1:0]                 mem_wr_addr,
    output logic [KEY_WIDTH-1:0]              mem_wr_data,
    output logic [ADDR_W-1:0]                 mem_rd_addr,
    input  logic [KEY_WIDTH-1:0]              mem_rd_data,
    // Result word
    output logic                              res_valid,
    input  logic                              res_ready,
    output ikt_pkg::res_t                     res
);

    localparam int NW = ikt_pkg::NUM_PORT_W;
    localparam int KP = ikt_pkg::KEY_PORT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REV,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    ikt_pkg::op_t           op_reg, op_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [NUM_W-1:0]       next_num_reg, next_num_next;
    logic [NUM_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [NUM_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   pend_reg, pend_next;
    ikt_pkg::res_t          res_reg, res_next;

    logic [NUM_W-1:0]       used;
    logic                   accept;
    logic                   hit;
    logic                   num_ok;
    logic [NUM_W+NW-1:0]    num_ext;
    logic [NUM_W+NW-1:0]    next_ext;
    logic [NUM_W+NW-1:0]    num_m1;
    logic [NUM_W-1:0]       hit_num;
    logic [NUM_W+NW-1:0]    hit_num_ext;
    logic [NUM_W+NW-1:0]    new_num_ext;
    logic [KEY_WIDTH+KP-1:0] rd_key_ext;

    assign used     = next_num_reg - NUM_W'(1);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Reverse lookup range check: 1 <= n < next_number
    assign num_ext  = {{NUM_W{1'b0}}, in_num};
    assign next_ext = {{NW{1'b0}}, next_num_reg};
    assign num_m1   = num_ext - (NUM_W+NW)'(1);
    assign num_ok   = (in_num != '0) && (num_ext < next_ext);

    // Compare the word read in the previous cycle
    assign hit         = pend_reg && (mem_rd_data == key_reg);
    assign hit_num     = pend_idx_reg + NUM_W'(1);
    assign hit_num_ext = {{NW{1'b0}}, hit_num};
    assign new_num_ext = {{NW{1'b0}}, next_num_reg};
    assign rd_key_ext  = {{KP{1'b0}}, mem_rd_data};

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        next_num_next = next_num_reg;
        scan_idx_next = scan_idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = 1'b0;
        res_next      = res_reg;
        mem_ctl       = '0;
        mem_rd_addr   = scan_idx_reg[ADDR_W-1:0];
        mem_wr_addr   = used[ADDR_W-1:0];
        mem_wr_data   = key_reg;

        unique case (state_reg)
            S_IDLE: begin
                // Take a word and dispatch on its opcode
                if (accept) begin
                    key_next      = in_key;
                    scan_idx_next = '0;
                    res_next.status = ikt_pkg::STAT_MISSING;
                    res_next.number = '0;
                    res_next.key    = '0;
                    case (in_op)
                        ikt_pkg::OP_INSERT, ikt_pkg::OP_FIND_KEY: begin
                            op_next    = ikt_pkg::op_t'(in_op);
                            state_next = S_SCAN;
                        end
                        ikt_pkg::OP_FIND_NUM: begin
                            op_next = ikt_pkg::OP_FIND_NUM;
                            if (num_ok) begin
                                mem_ctl.rd_en   = 1'b1;
                                mem_rd_addr     = num_m1[ADDR_W-1:0];
                                res_next.status = ikt_pkg::STAT_FOUND;
                                res_next.number = in_num;
                                state_next      = S_REV;
                            end else begin
                                state_next = S_RESP;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue one read a cycle, compare the previous one
                if (hit) begin
                    res_next.status = ikt_pkg::STAT_FOUND;
                    res_next.number = hit_num_ext[NW-1:0];
                    state_next      = S_RESP;
                end else if (scan_idx_reg < used) begin
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + NUM_W'(1);
                end else if (!pend_reg) begin
                    // Key absent: insert, report a full table, or report a miss
                    state_next = S_RESP;
                    if (op_reg == ikt_pkg::OP_INSERT) begin
                        if (used >= NUM_W'(CAPACITY)) begin
                            res_next.status = ikt_pkg::STAT_FULL;
                        end else begin
                            mem_ctl.wr_en   = 1'b1;
                            res_next.status = ikt_pkg::STAT_NEW;
                            res_next.number = new_num_ext[NW-1:0];
                            next_num_next   = next_num_reg + NUM_W'(1);
                        end
                    end
                end
            end

            S_REV: begin
                // Capture the stored key
                res_next.key = rd_key_ext[KP-1:0];
                state_next   = S_RESP;
            end

            S_RESP: begin
                // Hold until the output register frees up
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            next_num_reg <= NUM_W'(1);
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_num_reg <= next_num_next;
            pend_reg     <= pend_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        scan_idx_reg <= scan_idx_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
    end

    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

endmodule

/* rtl/ikt_out_stage.sv */
// Output register for the result channel; parts the sequencer from the receiver.
// Depends on ikt_pkg for the result word type.
`timescale 1ns / 1ps

module ikt_out_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             res_valid,
    output logic                             res_ready,
    input  ikt_pkg::res_t                    res,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ikt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [ikt_pkg::STAT_W-1:0]       m_axis_tuser
);

    logic                             valid_reg;
    logic [ikt_pkg::OUT_TDATA_W-1:0]  data_reg;
    logic [ikt_pkg::STAT_W-1:0]       user_reg;

    assign res_ready = !valid_reg || m_axis_tready;

    // Load a new word or drop the taken one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            data_reg <= {res.key, res.number};
            user_reg <= res.status;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;

endmodule

/* sim/tb_id_interning_table.sv */
// Self-checking testbench for id_interning_table: a scoreboard predicts each result word
// from its own copy of the table, and tasks drive random and directed request words.
// Depends on ikt_pkg and the id_interning_table RTL.
`timescale 1ns / 1ps

module tb_id_interning_table;

    localparam int KW = ikt_pkg::KEY_PORT_W;
    localparam int NW = ikt_pkg::NUM_PORT_W;
    localparam int OW = ikt_pkg::OP_W;
    localparam int SW = ikt_pkg::STAT_W;

    localparam logic [OW-1:0] OP_UNUSED   = 2'd3;
    localparam int            STALL_LIMIT = 4000;
    localparam int            DRAIN_WAIT  = ikt_pkg::CAPACITY_DEF + 40;
    localparam int            MAX_REPORTS = 200;

    // Own model of the table: stored keys, next number and the queue of expected words
    class intern_scoreboard;
        logic [KW-1:0]  stored_keys [ikt_pkg::CAPACITY_DEF];
        logic [8:0]     next_id;
        ikt_pkg::res_t  expected_replies [$];
        int unsigned    errors;

        function new();
            next_id = 9'd1;
            errors  = 0;
        endfunction

        // Scan stored keys in number order; 0 means no match
        function logic [8:0] find_id(logic [KW-1:0] k);
            for (int i = 0; i < int'(next_id) - 1; i++) begin
                if (stored_keys[i] == k) return 9'(i + 1);
            end
            return 9'd0;
        endfunction

        function int pending_count();
            return expected_replies.size();
        endfunction

        // Predict the reply to one accepted request word and update the table
        function void note_request(logic [OW-1:0] op, logic [KW-1:0] k, logic [NW-1:0] n);
            ikt_pkg::res_t r;
            logic [8:0]    hit;
            r.status = ikt_pkg::STAT_MISSING;
            r.number = '0;
            r.key    = '0;
            case (op)
                ikt_pkg::OP_INSERT: begin
                    hit = find_id(k);
                    if (hit != 9'd0) begin
                        r.status = ikt_pkg::STAT_FOUND;
                        r.number = hit[7:0];
                    end else if (int'(next_id) - 1 >= ikt_pkg::CAPACITY_DEF) begin
                        r.status = ikt_pkg::STAT_FULL;
                    end else begin
                        stored_keys[next_id - 9'd1] = k;
                        r.status = ikt_pkg::STAT_NEW;
                        r.number = next_id[7:0];
                        next_id  = next_id + 9'd1;
                    end
                end
                ikt_pkg::OP_FIND_KEY: begin
                    hit = find_id(k);
                    if (hit != 9'd0) begin
                        r.status = ikt_pkg::STAT_FOUND;
                        r.number = hit[7:0];
                    end
                end
                ikt_pkg::OP_FIND_NUM: begin
                    if (n != '0 && {1'b0, n} < next_id) begin
                        r.status = ikt_pkg::STAT_FOUND;
                        r.number = n;
                        r.key    = stored_keys[n - 8'd1];
                    end
                end
                default: begin
                    // unused opcode: not found, table untouched
                end
            endcase
            expected_replies.push_back(r);
        endfunction

        // Compare one result word with the oldest expectation
        function void check_reply(logic [SW-1:0] st, logic [NW-1:0] num, logic [KW-1:0] k);
            ikt_pkg::res_t r;
            if (expected_replies.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word with none expected: status %0d number %0d key %h",
                             $time, st, num, k);
                return;
            end
            r = expected_replies.pop_front();
            if (r.status !== st || r.number !== num || r.key !== k) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: mismatch: expected status %0d number %0d key %h, ",
                              "got status %0d number %0d key %h"},
                             $time, r.status, r.number, r.key, st, num, k);
            end
        endfunction
    endclass

    logic                               aclk          = 1'b0;
    logic                               aresetn       = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [ikt_pkg::IN_TDATA_W-1:0]     s_axis_tdata  = '0;
    logic [OW-1:0]                      s_axis_tuser  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [ikt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [SW-1:0]                      m_axis_tuser;

    int                     send_idle_pct = 20;
    int                     recv_idle_pct = 45;
    logic [KW-1:0]          known_keys [$];
    intern_scoreboard       replies = new();

    id_interning_table dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // key[63:0], local_number[71:64]
        .s_axis_tuser  (s_axis_tuser),   // opcode[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // result_number[7:0], result_key[71:8]
        .m_axis_tuser  (m_axis_tuser)    // status[1:0]
    );

    always #1 aclk = ~aclk;

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Note accepted requests, then check accepted results
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            replies.note_request(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[71:64]);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            replies.check_reply(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[71:8]);
    end

    // End the run when no word moves on either channel for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        wait (aresetn);
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("simulation failed");
        $finish;
    end

    // Present one request word, with random idle cycles ahead of it
    task automatic send_request(input logic [OW-1:0] op, input logic [KW-1:0] k,
                                input logic [NW-1:0] n);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {n, k};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Hold the request channel idle until every expected word has come back
    task automatic drain_replies();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (replies.pending_count() != 0) @(posedge aclk);
    endtask

    // Random requests: mostly inserts and lookups of keys already sent
    task automatic run_phase(input int count, input int send_pct, input int recv_pct);
        int            r;
        int            lim;
        logic [OW-1:0] op;
        logic [KW-1:0] k;
        logic [NW-1:0] n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain_replies();
            r = $urandom_range(99);
            k = {$urandom, $urandom};
            n = 8'($urandom_range(255));
            if (r < 40) begin
                op = ikt_pkg::OP_INSERT;
                if ($urandom_range(99) < 35 && known_keys.size() > 0)
                    k = known_keys[$urandom_range(known_keys.size() - 1)];
                else
                    known_keys.push_back(k);
            end else if (r < 65) begin
                op = ikt_pkg::OP_FIND_KEY;
                if (known_keys.size() > 0 && $urandom_range(99) < 75) begin
                    k = known_keys[$urandom_range(known_keys.size() - 1)];
                    // flip one bit now and then to test near misses
                    if ($urandom_range(99) < 15)
                        k = k ^ (64'd1 << $urandom_range(63));
                end
            end else if (r < 95) begin
                op = ikt_pkg::OP_FIND_NUM;
                if ($urandom_range(1) == 0) begin
                    lim = (known_keys.size() + 1 > 255) ? 255 : known_keys.size() + 1;
                    n   = 8'($urandom_range(lim));
                end
            end else begin
                op = OP_UNUSED;
            end
            send_request(op, k, n);
        end
        drain_replies();
    endtask

    initial begin
        // Hold reset, then release it
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty table, key extremes, duplicates, invalid numbers, unused opcode
        send_request(ikt_pkg::OP_FIND_NUM, 64'd0, 8'd1);
        send_request(ikt_pkg::OP_FIND_KEY, 64'd0, 8'd0);
        send_request(ikt_pkg::OP_INSERT, 64'd0, 8'hFF);
        send_request(ikt_pkg::OP_INSERT, '1, 8'd0);
        send_request(ikt_pkg::OP_INSERT, 64'd0, 8'd0);
        send_request(ikt_pkg::OP_FIND_KEY, '1, 8'd0);
        send_request(ikt_pkg::OP_FIND_KEY, 64'h5555_5555_5555_5555, 8'd0);
        send_request(ikt_pkg::OP_FIND_NUM, '1, 8'd0);
        send_request(ikt_pkg::OP_FIND_NUM, 64'd0, 8'd2);
        send_request(ikt_pkg::OP_FIND_NUM, 64'd0, 8'd3);
        send_request(ikt_pkg::OP_FIND_NUM, 64'd0, 8'hFF);
        send_request(OP_UNUSED, '1, 8'hFF);
        send_request(ikt_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55);
        send_request(ikt_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 8'h80);
        send_request(ikt_pkg::OP_INSERT, 64'd1, 8'd1);
        send_request(ikt_pkg::OP_FIND_KEY, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0);
        send_request(ikt_pkg::OP_FIND_NUM, 64'd0, 8'd5);
        send_request(ikt_pkg::OP_FIND_NUM, 64'd0, 8'd1);
        send_request(OP_UNUSED, 64'd0, 8'd0);
        known_keys.push_back(64'd0);
        known_keys.push_back('1);
        known_keys.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        known_keys.push_back(64'h8000_0000_0000_0000);
        known_keys.push_back(64'd1);
        drain_replies();

        // Random: receiver idles more, then sender idles more, then no idling
        run_phase(400, 20, 45);
        run_phase(400, 45, 20);
        run_phase(400, 0, 0);

        // Let any late word show up before the verdict
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (replies.errors == 0 && replies.pending_count() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ikt_pkg.sv
rtl/ikt_key_mem.sv
rtl/ikt_ctrl.sv
rtl/ikt_out_stage.sv
rtl/id_interning_table.sv
sim/tb_id_interning_table.sv
